// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// A condition that must never be seen while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// File: rtl/core/ist_pkg.sv
package ist_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } mem_req_t;

endpackage

// File: rtl/core/ist_store.sv
module ist_store
  import ist_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/ist_ctrl.sv
module ist_ctrl
  import ist_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [1:0]              in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                    busy,
  output mem_req_t                req,
  input  logic [DATA_W-1:0]       rd_data,
  output logic                    out_valid,
  output logic                    out_was_present,
  output logic [4:0]              out_entry_count,
  output logic                    out_refused
);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT} state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  didx_r, didx_nxt;
  logic              dv_r, dv_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              present_r, present_nxt;
  logic [4:0]        count_out_r, count_out_nxt;
  logic              refused_r, refused_nxt;
  logic              issue;
  logic              hit;
  logic [CNT_W-1:0]  prev_idx;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_dec;

  assign issue    = (idx_r < cnt_r);
  assign hit      = dv_r && (rd_data == value_r);
  assign prev_idx = didx_r - 1'b1;
  assign cnt_inc  = cnt_r + 1'b1;
  assign cnt_dec  = cnt_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    idx_nxt       = idx_r;
    didx_nxt      = didx_r;
    dv_nxt        = 1'b0;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    present_nxt   = present_r;
    count_out_nxt = count_out_r;
    refused_nxt   = refused_r;
    req.we        = 1'b0;
    req.waddr     = prev_idx[AW-1:0];
    req.wdata     = rd_data;
    req.raddr     = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          value_nxt = in_value;
          idx_nxt   = '0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          if (kind_r == KIND_REMOVE) begin
            idx_nxt   = didx_r + 1'b1;
            state_nxt = S_SHIFT;
          end else begin
            out_valid_nxt = 1'b1;
            present_nxt   = 1'b1;
            refused_nxt   = 1'b0;
            count_out_nxt = 5'(cnt_r);
            state_nxt     = S_IDLE;
          end
        end else if (!dv_r && !issue) begin
          out_valid_nxt = 1'b1;
          present_nxt   = 1'b0;
          refused_nxt   = 1'b0;
          count_out_nxt = 5'(cnt_r);
          state_nxt     = S_IDLE;
          if (kind_r == KIND_INSERT) begin
            if (cnt_r < CNT_W'(CAPACITY)) begin
              req.we        = 1'b1;
              req.waddr     = cnt_r[AW-1:0];
              req.wdata     = value_r;
              cnt_nxt       = cnt_inc;
              count_out_nxt = 5'(cnt_inc);
            end else begin
              refused_nxt = 1'b1;
            end
          end
        end else if (issue) begin
          dv_nxt   = 1'b1;
          didx_nxt = idx_r;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      S_SHIFT: begin
        // Entry read last cycle moves down one place.
        if (dv_r) begin
          req.we = 1'b1;
        end
        if (!dv_r && !issue) begin
          cnt_nxt       = cnt_dec;
          out_valid_nxt = 1'b1;
          present_nxt   = 1'b1;
          refused_nxt   = 1'b0;
          count_out_nxt = 5'(cnt_dec);
          state_nxt     = S_IDLE;
        end else if (issue) begin
          dv_nxt   = 1'b1;
          didx_nxt = idx_r;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dv_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r      <= kind_nxt;
    value_r     <= value_nxt;
    idx_r       <= idx_nxt;
    didx_r      <= didx_nxt;
    present_r   <= present_nxt;
    count_out_r <= count_out_nxt;
    refused_r   <= refused_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_was_present = present_r;
  assign out_entry_count = count_out_r;
  assign out_refused     = refused_r;

endmodule

// File: rtl/core/integer_set_table.sv
// The result strobe rises once a lookup over the held entries misses or hits, or, for a remove
// that hits, once the later entries have been moved down one place to close the gap.
// Throughput: one request at a time. busy drops with the strobe. The search and the shift walk
// the single read port one entry a cycle. Reset (rst_n low, synchronous) empties the set;
// results cannot be stalled.
module integer_set_table
  import ist_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic                     out_was_present,
  output logic [4:0]               out_entry_count,
  output logic                     out_refused
);

  // The element store is a small single-port-write, single-port-read memory.
  // Its contents are undefined after reset; the count is cleared, and
  // entries are never read at or above the count in a way that matters.
  mem_req_t          req;
  logic [DATA_W-1:0] rd_data;

  // The sequencer walks the store one entry per cycle. During the search it
  // issues a read each cycle and compares the registered read data with the
  // requested value in the cycle after, so the read port is the shared unit.
  // On a remove hit it then reads each later entry and writes it back one
  // place lower, again one entry per cycle, before the count drops by one.
  // An insert of an absent value writes at the count in the cycle that
  // the search ends, unless the set is full, in which case it is refused.
  ist_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .busy            (busy),
    .req             (req),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_was_present (out_was_present),
    .out_entry_count (out_entry_count),
    .out_refused     (out_refused)
  );

  ist_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/core/ist_checker.sv
`include "assert_macros.svh"

module ist_checker
  import ist_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               in_kind,
  input logic signed [DATA_W-1:0] in_value,
  input logic                     out_valid,
  input logic                     out_was_present,
  input logic [4:0]               out_entry_count,
  input logic                     out_refused
);

  // An accepted beat makes the block busy in the next cycle.
  `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  // A result is shown only once the request has finished.
  `ASSERT_CLK(a_result_idle, clk, rst_n, out_valid |-> !busy)
  // Two results never stand in consecutive cycles.
  `ASSERT_CLK(a_strobe_single, clk, rst_n, out_valid |=> !out_valid)
  // A refused insert means the set was full and the value absent.
  `ASSERT_CLK(a_refused_full, clk, rst_n,
    (out_valid && out_refused) |-> (out_entry_count == 5'(CAPACITY) && !out_was_present))
  // The count can never exceed the capacity.
  `ASSERT_NEVER(a_count_cap, clk, rst_n,
    out_valid && (CAPACITY < 32) && (out_entry_count > 5'(CAPACITY)))

endmodule

bind integer_set_table ist_checker u_chk (.*);

// File: sim/testbench.sv
// Self-checking bench for integer_set_table. Requests go in through the
// start/busy command port. Every accepted beat is run through a local model
// of the set, and the result it predicts, or a result typed in by hand, is
// queued. Each out_valid strobe is then checked against the oldest queued result.
module testbench;
  import ist_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The package names only insert and remove. A query is kind two. Kind
  // three has no meaning and must behave like a query.
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_BEATS = 850;
  localparam int POOL_SIZE    = 24;  // larger than CAPACITY so a full set still sees new values
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

  typedef struct packed {
    logic       was_present;
    logic [4:0] entry_count;
    logic       refused;
  } set_result_t;

  // One row of the directed table. Rows with has_literal set carry the
  // result typed in by hand. All other rows are checked against the model.
  typedef struct {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
    bit                       has_literal;
    set_result_t              literal;
  } directed_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic [1:0]               in_kind = KIND_QUERY;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     busy;
  logic                     out_valid;
  logic                     out_was_present;
  logic [4:0]               out_entry_count;
  logic                     out_refused;

  // Model state. This is a packed array plus a count, the same as the block
  // itself holds.
  logic signed [DATA_W-1:0] held_values [CAPACITY];
  int                       held_count;

  set_result_t              pending_results [$];
  directed_row_t            directed_rows [$];
  logic signed [DATA_W-1:0] value_pool [POOL_SIZE];
  bit                       fail_seen;
  int                       burst_left;

  always #2 clk = ~clk;

  integer_set_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_was_present (out_was_present),
    .out_entry_count (out_entry_count),
    .out_refused     (out_refused)
  );

  // Applies one request to the model set and returns the result it implies.
  // Only insert and remove change anything. Query and the spare kind just
  // report whether the value is held.
  function automatic set_result_t apply_request(input logic [1:0] kind,
                                                input logic signed [DATA_W-1:0] value);
    set_result_t res;
    int          slot;
    slot = -1;
    for (int i = 0; i < held_count; i++) begin
      if (slot < 0 && held_values[i] == value) slot = i;
    end
    res.was_present = (slot >= 0);
    res.refused     = 1'b0;
    case (kind)
      KIND_INSERT: begin
        if (slot < 0) begin
          if (held_count >= CAPACITY) begin
            res.refused = 1'b1;
          end else begin
            held_values[held_count] = value;
            held_count++;
          end
        end
      end
      KIND_REMOVE: begin
        // Entries after the hit each move down one place, which closes the gap.
        if (slot >= 0) begin
          for (int j = slot; j < held_count - 1; j++) held_values[j] = held_values[j + 1];
          held_count--;
        end
      end
      default: ;
    endcase
    res.entry_count = held_count[4:0];
    return res;
  endfunction

  // Holds start high until the block takes the beat. busy is read just after
  // the edge, before any update from that edge, so it is the value that the
  // block saw. The expectation is queued at the edge that accepted the beat.
  // The answer passes through the state register and the registered strobe, so
  // the monitor cannot pop in that same step.
  task automatic issue_request(input logic [1:0] kind, input logic signed [DATA_W-1:0] value,
                               input bit has_literal, input set_result_t literal);
    set_result_t predicted;
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (busy);
    predicted = apply_request(kind, value);
    pending_results.push_back(has_literal ? literal : predicted);
  endtask

  // Idle time between beats. Most gaps are short and a few are long. Bursts
  // of back-to-back beats are mixed in so that start also stays high from
  // one beat to the next. start is lowered only when a gap follows. In a
  // burst it is left high, so it never gets two assignments in one step.
  task automatic idle_between_beats();
    int pick;
    int gap;
    pick = $urandom_range(99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (pick < 4) begin
      burst_left = $urandom_range(40, 20);
      gap = 0;
    end else if (pick < 65) begin
      gap = 0;
    end else if (pick < 93) begin
      gap = $urandom_range(3, 1);
    end else begin
      gap = $urandom_range(40, 10);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Chooses a value for a random beat. Removes and queries mostly hit a held
  // value, so the search and the shift go deep into the array. Otherwise the
  // value comes from a small pool, which gives repeats, or it is fully random,
  // so every bit of the field toggles.
  function automatic logic signed [DATA_W-1:0] pick_value(input logic [1:0] kind);
    if (kind != KIND_INSERT && held_count > 0 && $urandom_range(9) < 6)
      return held_values[$urandom_range(held_count - 1)];
    if ($urandom_range(3) != 0)
      return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // Result monitor. The receiver cannot stall, so every strobe is a beat
  // that must match the oldest expectation.
  always @(posedge clk) begin
    set_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result was_present=%0d entry_count=%0d refused=%0d",
                 $time, out_was_present, out_entry_count, out_refused);
        fail_seen = 1'b1;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_was_present !== exp_res.was_present) begin
          $display("%0t: was_present expected %0d actual %0d",
                   $time, exp_res.was_present, out_was_present);
          fail_seen = 1'b1;
        end
        if (out_entry_count !== exp_res.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, exp_res.entry_count, out_entry_count);
          fail_seen = 1'b1;
        end
        if (out_refused !== exp_res.refused) begin
          $display("%0t: refused expected %0d actual %0d",
                   $time, exp_res.refused, out_refused);
          fail_seen = 1'b1;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    set_result_t no_literal;
    bit          filling;
    int          pick;
    logic [1:0]  kind;

    no_literal = '0;
    held_count = 0;
    burst_left = 0;
    fail_seen  = 1'b0;
    filling    = 1'b1;
    for (int i = 0; i < CAPACITY; i++) held_values[i] = '0;

    // The pool always contains the extremes, zero and minus one.
    value_pool[0] = VALUE_MIN;
    value_pool[1] = VALUE_MAX;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();

    // Directed table. It works the set from empty up to full and then down
    // again.
    // The empty set: a query and a remove of a value that is not held.
    directed_rows.push_back('{KIND_QUERY,  32'sd0,    1'b1, '{1'b0, 5'd0, 1'b0}});
    directed_rows.push_back('{KIND_REMOVE, 32'sd5,    1'b1, '{1'b0, 5'd0, 1'b0}});
    // Inserts of the extremes, then an insert of a value already present.
    directed_rows.push_back('{KIND_INSERT, VALUE_MIN, 1'b1, '{1'b0, 5'd1, 1'b0}});
    directed_rows.push_back('{KIND_INSERT, VALUE_MAX, 1'b1, '{1'b0, 5'd2, 1'b0}});
    directed_rows.push_back('{KIND_INSERT, VALUE_MIN, 1'b1, '{1'b1, 5'd2, 1'b0}});
    // The spare kind is a plain lookup. Then a query miss on all ones.
    directed_rows.push_back('{KIND_SPARE,  VALUE_MAX, 1'b1, '{1'b1, 5'd2, 1'b0}});
    directed_rows.push_back('{KIND_QUERY,  -32'sd1,   1'b1, '{1'b0, 5'd2, 1'b0}});
    // Fill up to capacity. These rows are checked by the model.
    for (int v = 1; v <= CAPACITY - 2; v++)
      directed_rows.push_back('{KIND_INSERT, 32'(v), 1'b0, no_literal});
    // A new value into a full set is refused. A held value is not.
    directed_rows.push_back('{KIND_INSERT, 32'sd100,  1'b1, '{1'b0, 5'd16, 1'b1}});
    directed_rows.push_back('{KIND_INSERT, VALUE_MAX, 1'b1, '{1'b1, 5'd16, 1'b0}});
    // Remove from the head, which is the longest shift, and then from the tail.
    directed_rows.push_back('{KIND_REMOVE, VALUE_MIN, 1'b1, '{1'b1, 5'd15, 1'b0}});
    directed_rows.push_back('{KIND_REMOVE, 32'sd14,   1'b1, '{1'b1, 5'd14, 1'b0}});
    directed_rows.push_back('{KIND_SPARE,  32'sd7,    1'b1, '{1'b1, 5'd14, 1'b0}});

    // Synchronous reset is held low, then released.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      issue_request(directed_rows[r].kind, directed_rows[r].value,
                    directed_rows[r].has_literal, directed_rows[r].literal);
      idle_between_beats();
    end

    // Random part. The mix of kinds alternates between filling and draining,
    // so the count sweeps over its whole range many times. Full-set refusals
    // and removes from an almost empty set both come up often.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (held_count == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      if (held_count == 0 && $urandom_range(1) == 0) filling = 1'b1;
      pick = $urandom_range(99);
      if (pick < (filling ? 55 : 20))      kind = KIND_INSERT;
      else if (pick < 75)                  kind = KIND_REMOVE;
      else if (pick < 95)                  kind = KIND_QUERY;
      else                                 kind = KIND_SPARE;
      issue_request(kind, pick_value(kind), 1'b0, no_literal);
      idle_between_beats();
    end

    // Drop start at the next edge. Then wait for the last results, plus a
    // margin longer than any request, to catch any stray strobe.
    @(posedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!fail_seen) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog. About 876 beats, each at its longest request time and gap,
  // take well under 250 us. Allow several times that.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
